// ===== sv/lhw_pkg.sv =====
// package with shared types and constants for the link heartbeat watchdog
`default_nettype none

package lhw_pkg;

  typedef enum logic [1:0] {
    ACT_TICK        = 2'd0,
    ACT_FRAME_GREEN = 2'd1,
    ACT_FRAME_QUIET = 2'd2,
    ACT_ACK         = 2'd3
  } action_t;

  typedef enum logic {
    REG_HEARTBEAT = 1'b0,
    REG_TIMEOUT   = 1'b1
  } reg_index_t;

  localparam int unsigned HB_BITS = 22;
  localparam int unsigned TO_BITS = 16;
  localparam int unsigned CFG_BITS = 22;

  localparam logic [HB_BITS-1:0] HB_RESET = HB_BITS'(3333);
  localparam logic [TO_BITS-1:0] TO_RESET = TO_BITS'(10000);

  localparam int unsigned GREEN_PULSE     = 120;
  localparam int unsigned RED_STALE_PULSE = 50;
  localparam int unsigned RED_ACK_PULSE   = 150;
  localparam int unsigned STALE_PERIOD    = 1000;
  localparam int unsigned STALE_MIN       = 500;
  localparam int unsigned SPIN_INTERVAL   = 250;

endpackage

`default_nettype wire

// ===== sv/link_heartbeat_watchdog_unit.sv =====
// link heartbeat watchdog: led pulse, stale blink, timeout and spinner logic
// an accepted input item passes through the input register and then the result register to the output
// throughput: one item per clock cycle while the output is taken, set by the single-pass state update
// the input register stalls only while the output register holds an untaken item
// reset (synchronous, active high) restores register defaults and watchdog state
`default_nettype none

module link_heartbeat_watchdog_unit #(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // now_ms[31:0]
  input  wire logic [1:0]  s_axis_tuser,   // action[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // green_led, red_led, link_up, link_lost,
                                           // spinner_phase[1:0], zero pad[1:0]
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [lhw_pkg::CFG_BITS-1:0] cfg_data
);

  localparam int unsigned TB = TIME_BITS;
  localparam logic [TB-1:0] T_GREEN = TB'(lhw_pkg::GREEN_PULSE);
  localparam logic [TB-1:0] T_RED_STALE = TB'(lhw_pkg::RED_STALE_PULSE);
  localparam logic [TB-1:0] T_RED_ACK = TB'(lhw_pkg::RED_ACK_PULSE);
  localparam logic [TB-1:0] T_PERIOD = TB'(lhw_pkg::STALE_PERIOD);
  localparam logic [TB-1:0] T_SPIN = TB'(lhw_pkg::SPIN_INTERVAL);
  localparam logic [lhw_pkg::HB_BITS:0] THR_MIN = (lhw_pkg::HB_BITS + 1)'(lhw_pkg::STALE_MIN);

  // configuration
  logic [lhw_pkg::HB_BITS-1:0] heartbeat_interval;
  logic [lhw_pkg::TO_BITS-1:0] frame_timeout;

  always_ff @(posedge clk) begin
    if (rst) begin
      heartbeat_interval <= lhw_pkg::HB_RESET;
      frame_timeout      <= lhw_pkg::TO_RESET;
    end else if (cfg_we) begin
      unique case (lhw_pkg::reg_index_t'(cfg_index))
        lhw_pkg::REG_HEARTBEAT: heartbeat_interval <= cfg_data[lhw_pkg::HB_BITS-1:0];
        lhw_pkg::REG_TIMEOUT:   frame_timeout <= cfg_data[lhw_pkg::TO_BITS-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic              in_valid;
  lhw_pkg::action_t  in_action;
  logic [31:0]       in_now;
  logic              advance;
  logic              step;

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign step          = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_action <= lhw_pkg::action_t'(s_axis_tuser);
      in_now    <= s_axis_tdata;
    end
  end

  // watchdog state
  logic          link_alive, link_alive_next;
  logic [TB-1:0] last_frame_time, last_frame_time_next;
  logic [TB-1:0] last_spin_time, last_spin_time_next;
  logic [1:0]    spin_count, spin_count_next;
  logic [TB-1:0] green_expiry, green_expiry_next;
  logic [TB-1:0] red_expiry, red_expiry_next;
  logic [TB-1:0] next_stale_blink, next_stale_blink_next;
  logic          green_level, green_level_next;
  logic          red_level, red_level_next;
  logic          lost_next;

  function automatic logic reached(input logic [TB-1:0] now, input logic [TB-1:0] t);
    logic [TB-1:0] diff;
    diff = now - t;
    return !diff[TB-1];
  endfunction

  function automatic logic [TB-1:0] pulse_end(input logic [TB-1:0] now,
                                              input logic [TB-1:0] dur,
                                              input logic [TB-1:0] cur);
    logic [TB-1:0] e;
    e = now + dur;
    if (e < now) e = now;
    if (e < cur) e = cur;
    return e;
  endfunction

  logic [TB-1:0]                now;
  logic [TB-1:0]                since;
  logic [TB-1:0]                timeout_ext;
  logic [lhw_pkg::HB_BITS:0]    thr_wide;
  logic [lhw_pkg::TO_BITS-1:0]  thr;
  logic [TB-1:0]                thr_ext;

  assign now         = TB'(in_now);
  assign since       = now - last_frame_time;
  assign timeout_ext = TB'(frame_timeout);

  always_comb begin
    thr_wide = {heartbeat_interval, 1'b0};
    if (thr_wide < THR_MIN) thr_wide = THR_MIN;
    if (thr_wide > (lhw_pkg::HB_BITS + 1)'(frame_timeout)) begin
      thr = frame_timeout;
    end else begin
      thr = thr_wide[lhw_pkg::TO_BITS-1:0];
    end
  end

  assign thr_ext = TB'(thr);

  always_comb begin
    link_alive_next       = link_alive;
    last_frame_time_next  = last_frame_time;
    last_spin_time_next   = last_spin_time;
    spin_count_next       = spin_count;
    green_expiry_next     = green_expiry;
    red_expiry_next       = red_expiry;
    next_stale_blink_next = next_stale_blink;
    green_level_next      = green_level;
    red_level_next        = red_level;
    lost_next             = 1'b0;

    unique case (in_action)
      lhw_pkg::ACT_TICK: begin
        if (link_alive) begin
          if (since > timeout_ext) begin
            link_alive_next       = 1'b0;
            spin_count_next       = 2'd0;
            last_spin_time_next   = now;
            green_expiry_next     = '0;
            red_expiry_next       = '0;
            green_level_next      = 1'b0;
            red_level_next        = 1'b0;
            next_stale_blink_next = now + T_PERIOD;
            lost_next             = 1'b1;
          end
        end else if ((now - last_spin_time) >= T_SPIN) begin
          spin_count_next     = spin_count + 2'd1;
          last_spin_time_next = now;
        end

        // pulse expiry
        if (green_expiry_next != '0 && reached(now, green_expiry_next)) begin
          green_expiry_next = '0;
          green_level_next  = 1'b0;
        end
        if (red_expiry_next != '0 && reached(now, red_expiry_next)) begin
          red_expiry_next = '0;
          red_level_next  = 1'b0;
        end

        if (link_alive_next) begin
          if (since >= thr_ext && since < timeout_ext) begin
            if (next_stale_blink_next == '0 || reached(now, next_stale_blink_next)) begin
              red_expiry_next       = pulse_end(now, T_RED_STALE, red_expiry_next);
              red_level_next        = 1'b1;
              next_stale_blink_next = now + T_PERIOD;
            end
          end else begin
            next_stale_blink_next = now + T_PERIOD;
            if (red_expiry_next == '0) red_level_next = 1'b0;
          end
        end else begin
          next_stale_blink_next = now + T_PERIOD;
          if (red_expiry_next == '0) red_level_next = !spin_count_next[0];
          if (green_expiry_next == '0) green_level_next = 1'b0;
        end
      end
      lhw_pkg::ACT_FRAME_GREEN, lhw_pkg::ACT_FRAME_QUIET: begin
        link_alive_next       = 1'b1;
        last_frame_time_next  = now;
        spin_count_next       = 2'd0;
        last_spin_time_next   = now;
        next_stale_blink_next = now + T_PERIOD;
        if (in_action == lhw_pkg::ACT_FRAME_GREEN) begin
          green_expiry_next = pulse_end(now, T_GREEN, green_expiry);
          green_level_next  = 1'b1;
        end
        if (red_expiry == '0) red_level_next = 1'b0;
      end
      lhw_pkg::ACT_ACK: begin
        red_expiry_next       = pulse_end(now, T_RED_ACK, red_expiry);
        red_level_next        = 1'b1;
        next_stale_blink_next = now + T_PERIOD;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_alive       <= 1'b0;
      last_frame_time  <= '0;
      last_spin_time   <= '0;
      spin_count       <= 2'd0;
      green_expiry     <= '0;
      red_expiry       <= '0;
      next_stale_blink <= T_PERIOD;
      green_level      <= 1'b0;
      red_level        <= 1'b0;
    end else if (step) begin
      link_alive       <= link_alive_next;
      last_frame_time  <= last_frame_time_next;
      last_spin_time   <= last_spin_time_next;
      spin_count       <= spin_count_next;
      green_expiry     <= green_expiry_next;
      red_expiry       <= red_expiry_next;
      next_stale_blink <= next_stale_blink_next;
      green_level      <= green_level_next;
      red_level        <= red_level_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_axis_tdata <= {2'b00, spin_count_next, lost_next, link_alive_next,
                       red_level_next, green_level_next};
    end
  end

endmodule

`default_nettype wire
